// ===== rtl/voxel_grid_centroid_downsampler_defines.svh =====
// assertion macros used by the voxel grid downsampler top level
`ifndef VOXEL_GRID_CENTROID_DOWNSAMPLER_DEFINES_SVH
`define VOXEL_GRID_CENTROID_DOWNSAMPLER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define VGCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define VGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vgcd_pkg.sv =====
// shared constants, types and states of the voxel grid downsampler
package vgcd_pkg;

    // table geometry and field widths
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_BITS    = 24;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_W       = 32 + COUNT_BITS;
    localparam int EDGE_W      = 31;
    localparam int PADDR_W     = 3;

    // divider chain widths: dividend magnitude and divisor
    localparam int DIV_W   = (SUM_W > 51) ? SUM_W : 51;
    localparam int DVS_W   = 34;
    localparam int HREM_W  = DVS_W + 1;
    localparam int HSUM_W  = HREM_W + 1;
    localparam int PROD2_W = HSUM_W + 18;
    localparam int PROD1_W = KEY_BITS + 18;

    // hash and limit constants
    localparam logic signed [17:0]      HASH_MUL   = 18'sd116101;
    localparam logic [DVS_W-1:0]        HASH_MOD   = 34'd10000000000;
    localparam logic [EDGE_W-1:0]       EDGE_MIN   = 31'd655;
    localparam logic [EDGE_W-1:0]       EDGE_RESET = 31'd65536;
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX  = '1;

    // register index within the apb window
    localparam logic [PADDR_W-3:0] REG_VOXEL_EDGE = '0;

    typedef logic signed [DIV_W:0] t_sdiv;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_MERGED    = 3'd1,
        ST_FULL      = 3'd2,
        ST_DISABLED  = 3'd3,
        ST_SATURATED = 3'd4,
        ST_EMITTED   = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        DK_KEY_X, DK_KEY_Y, DK_KEY_Z, DK_HASH, DK_CEN_X, DK_CEN_Y, DK_CEN_Z
    } t_div_kind;

    typedef struct packed {
        logic      neg;
        t_div_kind kind;
    } t_div_tag;

    // one word moving down the divider chain
    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [DIV_W-1:0] dq;
        logic [DVS_W-1:0] dvs;
        t_div_tag         tag;
    } t_div_word;

    // one hash table slot
    typedef struct packed {
        logic                  used;
        logic [KEY_BITS-1:0]   kx;
        logic [KEY_BITS-1:0]   ky;
        logic [KEY_BITS-1:0]   kz;
        logic [SUM_W-1:0]      sx;
        logic [SUM_W-1:0]      sy;
        logic [SUM_W-1:0]      sz;
        logic [COUNT_BITS-1:0] cnt;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_KISS, S_KWAIT, S_H1MUL, S_H1ISS, S_H1W, S_H2MUL,
        S_H2ISS, S_H2W, S_HOME, S_PRD, S_PCHK, S_DRD, S_DCHK, S_CISS, S_CWAIT,
        S_RESULT
    } t_state;

endpackage

// ===== rtl/voxel_grid_centroid_downsampler.sv =====
// top level of the voxel grid centroid downsampler
// Usage:
// s_axis carries one word per command: tuser is the op (0 add point, 1 drain),
// tdata the point x, y, z in signed Q16.16. m_axis returns exactly one word per
// command: tuser is the status, tdata the centroid x, y, z, tlast the last flag.
// The voxel edge is written over the apb port at byte address 0; the user
// must do so only while idle, as the block itself does not enforce it.
// Rate: one command at a time. An add runs three floor divisions and two hash
// remainders through the 51-cell divider chain, then probes slots of the table
// one by one. A drain scans slots from the drain cursor, then runs the three
// centroid divisions. Disabled and empty answers go straight to the result.
// Reset: a clearing pass writes every table slot as unused; no command is taken
// during it, apb writes are taken as ever.
// Stall: a finished word waits in the output register; the next command is
// already taken and worked on, and its result waits until the register frees.
`include "voxel_grid_centroid_downsampler_defines.svh"

module voxel_grid_centroid_downsampler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [95:0]                     s_axis_tdata,  // px, py, pz
    input  logic [0:0]                      s_axis_tuser,  // op
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [95:0]                     m_axis_tdata,  // cx, cy, cz
    output logic [2:0]                      m_axis_tuser,  // status
    output logic                            m_axis_tlast,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vgcd_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    vgcd_pkg::t_state                           r_state, n_state;
    logic [vgcd_pkg::EDGE_W-1:0]                r_edge;
    logic signed [31:0]                         r_p [3];
    logic signed [vgcd_pkg::KEY_BITS-1:0]       r_key [3];
    logic signed [vgcd_pkg::HREM_W-1:0]         r_hrem;
    vgcd_pkg::t_sdiv                            r_prod;
    logic [1:0]                                 r_iss;
    logic [1:0]                                 r_rcv;
    logic [vgcd_pkg::ADDR_W-1:0]                r_addr;
    logic [vgcd_pkg::ADDR_W-1:0]                r_probe;
    logic [vgcd_pkg::ADDR_W-1:0]                r_cursor;
    logic [vgcd_pkg::ADDR_W:0]                  r_used_cnt;
    logic signed [vgcd_pkg::SUM_W-1:0]          r_sum [3];
    logic [vgcd_pkg::COUNT_BITS-1:0]            r_cnt;
    logic [31:0]                                r_cen [3];
    vgcd_pkg::t_status                          r_res_status;
    logic                                       r_res_last;
    logic                                       r_ovld;
    vgcd_pkg::t_status                          r_ostatus;
    logic [95:0]                                r_odata;
    logic                                       r_olast;

    logic                                       w_accept;
    logic                                       w_in_rdy;
    logic                                       w_disabled;
    logic                                       w_out_free;
    logic                                       w_cfg_wr;
    logic                                       w_we;
    vgcd_pkg::t_entry                           w_wdata;
    vgcd_pkg::t_entry                           w_rd;
    vgcd_pkg::t_entry                           w_new_ent;
    vgcd_pkg::t_entry                           w_merge_ent;
    logic                                       w_match;
    logic                                       w_probe_end;
    logic                                       w_div_vld;
    vgcd_pkg::t_sdiv                            w_div_sv;
    vgcd_pkg::t_sdiv                            w_div_abs;
    logic [vgcd_pkg::DVS_W-1:0]                 w_div_dvs;
    vgcd_pkg::t_div_tag                         w_div_tag;
    logic                                       w_div_o_vld;
    logic [vgcd_pkg::DIV_W-1:0]                 w_div_quo;
    logic [vgcd_pkg::DVS_W-1:0]                 w_div_rem;
    vgcd_pkg::t_div_tag                         w_div_otag;
    logic [vgcd_pkg::DIV_W-1:0]                 w_qs;
    logic signed [vgcd_pkg::HREM_W-1:0]         w_hr;
    logic signed [31:0]                         w_p_sel;
    logic signed [vgcd_pkg::SUM_W-1:0]          w_sum_sel;
    vgcd_pkg::t_div_kind                        w_key_kind;
    vgcd_pkg::t_div_kind                        w_cen_kind;
    logic signed [vgcd_pkg::SUM_W:0]            w_cen_dvd;
    logic signed [vgcd_pkg::PROD1_W-1:0]        w_m1;
    logic signed [vgcd_pkg::HSUM_W-1:0]         w_hsum;
    logic signed [vgcd_pkg::PROD2_W-1:0]        w_m2;
    logic signed [vgcd_pkg::HSUM_W-1:0]         w_home;

    // handshakes and simple flags
    assign w_accept   = s_axis_tvalid && w_in_rdy;
    assign w_disabled = (r_edge < vgcd_pkg::EDGE_MIN);
    assign w_out_free = !r_ovld || m_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // apb read side
    assign pready = 1'b1;
    assign prdata = (paddr[vgcd_pkg::PADDR_W-1:2] == vgcd_pkg::REG_VOXEL_EDGE) ?
                    {1'b0, r_edge} : 32'd0;

    // per-iteration operand select
    always_comb begin
        case (r_iss)
            2'd0: begin
                w_p_sel    = r_p[0];
                w_sum_sel  = r_sum[0];
                w_key_kind = vgcd_pkg::DK_KEY_X;
                w_cen_kind = vgcd_pkg::DK_CEN_X;
            end
            2'd1: begin
                w_p_sel    = r_p[1];
                w_sum_sel  = r_sum[1];
                w_key_kind = vgcd_pkg::DK_KEY_Y;
                w_cen_kind = vgcd_pkg::DK_CEN_Y;
            end
            default: begin
                w_p_sel    = r_p[2];
                w_sum_sel  = r_sum[2];
                w_key_kind = vgcd_pkg::DK_KEY_Z;
                w_cen_kind = vgcd_pkg::DK_CEN_Z;
            end
        endcase
    end

    // centroid dividend: sum plus half the count
    assign w_cen_dvd = (vgcd_pkg::SUM_W+1)'(w_sum_sel)
                     + (vgcd_pkg::SUM_W+1)'({1'b0, r_cnt[vgcd_pkg::COUNT_BITS-1:1]});

    // hash products and home slot
    assign w_m1   = r_key[2] * vgcd_pkg::HASH_MUL;
    assign w_hsum = vgcd_pkg::HSUM_W'(r_hrem) + vgcd_pkg::HSUM_W'(r_key[1]);
    assign w_m2   = w_hsum * vgcd_pkg::HASH_MUL;
    assign w_home = vgcd_pkg::HSUM_W'(r_hrem) + vgcd_pkg::HSUM_W'(r_key[0]);

    // probe compare and slot updates
    assign w_match = (w_rd.kx == r_key[0]) && (w_rd.ky == r_key[1]) && (w_rd.kz == r_key[2]);
    assign w_probe_end = (r_probe == vgcd_pkg::ADDR_W'(vgcd_pkg::TABLE_DEPTH - 1));

    always_comb begin
        w_new_ent     = '0;
        w_new_ent.used = 1'b1;
        w_new_ent.kx  = r_key[0];
        w_new_ent.ky  = r_key[1];
        w_new_ent.kz  = r_key[2];
        w_new_ent.sx  = vgcd_pkg::SUM_W'(r_p[0]);
        w_new_ent.sy  = vgcd_pkg::SUM_W'(r_p[1]);
        w_new_ent.sz  = vgcd_pkg::SUM_W'(r_p[2]);
        w_new_ent.cnt = vgcd_pkg::COUNT_BITS'(1);
        w_merge_ent     = w_rd;
        w_merge_ent.sx  = w_rd.sx + vgcd_pkg::SUM_W'(r_p[0]);
        w_merge_ent.sy  = w_rd.sy + vgcd_pkg::SUM_W'(r_p[1]);
        w_merge_ent.sz  = w_rd.sz + vgcd_pkg::SUM_W'(r_p[2]);
        w_merge_ent.cnt = w_rd.cnt + vgcd_pkg::COUNT_BITS'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vgcd_pkg::S_CLEAR: begin
                if (r_addr == vgcd_pkg::ADDR_W'(vgcd_pkg::TABLE_DEPTH - 1)) begin
                    n_state = vgcd_pkg::S_IDLE;
                end
            end
            vgcd_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_disabled || (s_axis_tuser[0] && (r_used_cnt == '0))) begin
                        n_state = vgcd_pkg::S_RESULT;
                    end else if (s_axis_tuser[0]) begin
                        n_state = vgcd_pkg::S_DRD;
                    end else begin
                        n_state = vgcd_pkg::S_KISS;
                    end
                end
            end
            vgcd_pkg::S_KISS: begin
                if (r_iss == 2'd2) n_state = vgcd_pkg::S_KWAIT;
            end
            vgcd_pkg::S_KWAIT: begin
                if (r_rcv == 2'd3) n_state = vgcd_pkg::S_H1MUL;
            end
            vgcd_pkg::S_H1MUL: n_state = vgcd_pkg::S_H1ISS;
            vgcd_pkg::S_H1ISS: n_state = vgcd_pkg::S_H1W;
            vgcd_pkg::S_H1W: begin
                if (r_rcv == 2'd1) n_state = vgcd_pkg::S_H2MUL;
            end
            vgcd_pkg::S_H2MUL: n_state = vgcd_pkg::S_H2ISS;
            vgcd_pkg::S_H2ISS: n_state = vgcd_pkg::S_H2W;
            vgcd_pkg::S_H2W: begin
                if (r_rcv == 2'd1) n_state = vgcd_pkg::S_HOME;
            end
            vgcd_pkg::S_HOME: n_state = vgcd_pkg::S_PRD;
            vgcd_pkg::S_PRD:  n_state = vgcd_pkg::S_PCHK;
            vgcd_pkg::S_PCHK: begin
                if (!w_rd.used || w_match || w_probe_end) begin
                    n_state = vgcd_pkg::S_RESULT;
                end else begin
                    n_state = vgcd_pkg::S_PRD;
                end
            end
            vgcd_pkg::S_DRD: n_state = vgcd_pkg::S_DCHK;
            vgcd_pkg::S_DCHK: begin
                n_state = w_rd.used ? vgcd_pkg::S_CISS : vgcd_pkg::S_DRD;
            end
            vgcd_pkg::S_CISS: begin
                if (r_iss == 2'd2) n_state = vgcd_pkg::S_CWAIT;
            end
            vgcd_pkg::S_CWAIT: begin
                if (r_rcv == 2'd3) n_state = vgcd_pkg::S_RESULT;
            end
            vgcd_pkg::S_RESULT: begin
                if (w_out_free) n_state = vgcd_pkg::S_IDLE;
            end
            default: n_state = vgcd_pkg::S_CLEAR;
        endcase
    end

    // control outputs: ready, table write, divider issue
    always_comb begin
        w_in_rdy       = 1'b0;
        w_we           = 1'b0;
        w_wdata        = '0;
        w_div_vld      = 1'b0;
        w_div_sv       = '0;
        w_div_dvs      = '0;
        w_div_tag.kind = vgcd_pkg::DK_KEY_X;
        case (r_state)
            vgcd_pkg::S_IDLE:  w_in_rdy = 1'b1;
            vgcd_pkg::S_CLEAR: w_we = 1'b1;
            vgcd_pkg::S_KISS: begin
                w_div_vld      = 1'b1;
                w_div_sv       = vgcd_pkg::t_sdiv'(w_p_sel);
                w_div_dvs      = vgcd_pkg::DVS_W'(r_edge);
                w_div_tag.kind = w_key_kind;
            end
            vgcd_pkg::S_H1ISS, vgcd_pkg::S_H2ISS: begin
                w_div_vld      = 1'b1;
                w_div_sv       = r_prod;
                w_div_dvs      = vgcd_pkg::HASH_MOD;
                w_div_tag.kind = vgcd_pkg::DK_HASH;
            end
            vgcd_pkg::S_CISS: begin
                w_div_vld      = 1'b1;
                w_div_sv       = vgcd_pkg::t_sdiv'(w_cen_dvd);
                w_div_dvs      = vgcd_pkg::DVS_W'(r_cnt);
                w_div_tag.kind = w_cen_kind;
            end
            vgcd_pkg::S_PCHK: begin
                if (!w_rd.used) begin
                    w_we    = 1'b1;
                    w_wdata = w_new_ent;
                end else if (w_match && (w_rd.cnt != vgcd_pkg::COUNT_MAX)) begin
                    w_we    = 1'b1;
                    w_wdata = w_merge_ent;
                end
            end
            vgcd_pkg::S_DCHK: w_we = w_rd.used;
            default: ;
        endcase
        w_div_tag.neg = w_div_sv[vgcd_pkg::DIV_W];
    end

    // magnitude into the divider
    assign w_div_abs = w_div_sv[vgcd_pkg::DIV_W] ? -w_div_sv : w_div_sv;

    vgcd_div_chain u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_div_vld),
        .i_dvd   (w_div_abs[vgcd_pkg::DIV_W-1:0]),
        .i_dvs   (w_div_dvs),
        .i_tag   (w_div_tag),
        .o_vld   (w_div_o_vld),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem),
        .o_tag   (w_div_otag)
    );

    // floor quotient and truncating remainder from magnitudes
    always_comb begin
        if (w_div_otag.neg) begin
            w_qs = (|w_div_rem) ? ~w_div_quo : -w_div_quo;
            w_hr = -(vgcd_pkg::HREM_W'(w_div_rem));
        end else begin
            w_qs = w_div_quo;
            w_hr = vgcd_pkg::HREM_W'(w_div_rem);
        end
    end

    vgcd_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rd)
    );

    // state, configuration and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= vgcd_pkg::S_CLEAR;
            r_edge     <= vgcd_pkg::EDGE_RESET;
            r_addr     <= '0;
            r_probe    <= '0;
            r_cursor   <= '0;
            r_used_cnt <= '0;
            r_iss      <= '0;
            r_rcv      <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr && (paddr[vgcd_pkg::PADDR_W-1:2] == vgcd_pkg::REG_VOXEL_EDGE)) begin
                r_edge <= pwdata[vgcd_pkg::EDGE_W-1:0];
            end
            // output word leaves unless a new one takes its place
            if (r_ovld && m_axis_tready && (r_state != vgcd_pkg::S_RESULT)) begin
                r_ovld <= 1'b0;
            end

            // divider results land by kind
            if (w_div_o_vld) begin
                r_rcv <= r_rcv + 2'd1;
                case (w_div_otag.kind)
                    vgcd_pkg::DK_KEY_X: r_key[0] <= w_qs[vgcd_pkg::KEY_BITS-1:0];
                    vgcd_pkg::DK_KEY_Y: r_key[1] <= w_qs[vgcd_pkg::KEY_BITS-1:0];
                    vgcd_pkg::DK_KEY_Z: r_key[2] <= w_qs[vgcd_pkg::KEY_BITS-1:0];
                    vgcd_pkg::DK_HASH:  r_hrem   <= w_hr;
                    vgcd_pkg::DK_CEN_X: r_cen[0] <= w_qs[31:0];
                    vgcd_pkg::DK_CEN_Y: r_cen[1] <= w_qs[31:0];
                    vgcd_pkg::DK_CEN_Z: r_cen[2] <= w_qs[31:0];
                    default: ;
                endcase
            end

            case (r_state)
                vgcd_pkg::S_CLEAR: r_addr <= r_addr + 1'b1;
                vgcd_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_p[0]     <= s_axis_tdata[31:0];
                        r_p[1]     <= s_axis_tdata[63:32];
                        r_p[2]     <= s_axis_tdata[95:64];
                        r_cen[0]   <= '0;
                        r_cen[1]   <= '0;
                        r_cen[2]   <= '0;
                        r_res_last <= !w_disabled && s_axis_tuser[0] && (r_used_cnt == '0);
                        r_iss      <= '0;
                        r_rcv      <= '0;
                        if (w_disabled) begin
                            r_res_status <= vgcd_pkg::ST_DISABLED;
                        end else if (s_axis_tuser[0]) begin
                            if (r_used_cnt == '0) begin
                                r_res_status <= vgcd_pkg::ST_EMPTY;
                                r_cursor     <= '0;
                            end else begin
                                r_addr <= r_cursor;
                            end
                        end
                    end
                end
                vgcd_pkg::S_KISS: r_iss <= r_iss + 2'd1;
                vgcd_pkg::S_H1MUL: begin
                    r_prod <= vgcd_pkg::t_sdiv'(w_m1);
                    r_rcv  <= '0;
                end
                vgcd_pkg::S_H2MUL: begin
                    r_prod <= w_m2[vgcd_pkg::DIV_W:0];
                    r_rcv  <= '0;
                end
                vgcd_pkg::S_HOME: begin
                    r_addr  <= w_home[vgcd_pkg::ADDR_W-1:0];
                    r_probe <= '0;
                end
                vgcd_pkg::S_PCHK: begin
                    if (!w_rd.used) begin
                        r_res_status <= vgcd_pkg::ST_NEW;
                        r_used_cnt   <= r_used_cnt + 1'b1;
                    end else if (w_match) begin
                        r_res_status <= (w_rd.cnt == vgcd_pkg::COUNT_MAX) ?
                                        vgcd_pkg::ST_SATURATED : vgcd_pkg::ST_MERGED;
                    end else if (w_probe_end) begin
                        r_res_status <= vgcd_pkg::ST_FULL;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_probe <= r_probe + 1'b1;
                    end
                end
                vgcd_pkg::S_DCHK: begin
                    if (w_rd.used) begin
                        r_sum[0]   <= w_rd.sx;
                        r_sum[1]   <= w_rd.sy;
                        r_sum[2]   <= w_rd.sz;
                        r_cnt      <= w_rd.cnt;
                        r_used_cnt <= r_used_cnt - 1'b1;
                        r_cursor   <= r_addr + 1'b1;
                        r_iss      <= '0;
                        r_rcv      <= '0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                vgcd_pkg::S_CISS: r_iss <= r_iss + 2'd1;
                vgcd_pkg::S_CWAIT: begin
                    if (r_rcv == 2'd3) begin
                        r_res_status <= vgcd_pkg::ST_EMITTED;
                        r_res_last   <= (r_used_cnt == '0);
                    end
                end
                vgcd_pkg::S_RESULT: begin
                    if (w_out_free) begin
                        r_ovld    <= 1'b1;
                        r_ostatus <= r_res_status;
                        r_odata   <= {r_cen[2], r_cen[1], r_cen[0]};
                        r_olast   <= r_res_last;
                    end
                end
                default: ;
            endcase
        end
    end

    // output port drive
    assign s_axis_tready = w_in_rdy;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tlast  = r_olast;

    // checks on sequencing
    `VGCD_ASSERT_SAME(a_no_accept_in_clear, r_state == vgcd_pkg::S_CLEAR, !s_axis_tready, "command taken during table clear")
    `VGCD_ASSERT_SAME(a_write_states, w_we, (r_state == vgcd_pkg::S_CLEAR) || (r_state == vgcd_pkg::S_PCHK) || (r_state == vgcd_pkg::S_DCHK), "table written outside clear or check")
    `VGCD_ASSERT_SAME(a_div_out_states, w_div_o_vld, (r_state == vgcd_pkg::S_KISS) || (r_state == vgcd_pkg::S_KWAIT) || (r_state == vgcd_pkg::S_H1W) || (r_state == vgcd_pkg::S_H2W) || (r_state == vgcd_pkg::S_CISS) || (r_state == vgcd_pkg::S_CWAIT), "divider result with nobody waiting")
    `VGCD_ASSERT_NEXT(a_result_held, (r_state == vgcd_pkg::S_RESULT) && m_axis_tvalid && !m_axis_tready, r_state == vgcd_pkg::S_RESULT, "result overwrote a stalled word")

endmodule

// ===== rtl/vgcd_div_cell.sv =====
// one restoring division step, registered
module vgcd_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  vgcd_pkg::t_div_word  i_word,
    output logic                 o_vld,
    output vgcd_pkg::t_div_word  o_word
);

    logic [vgcd_pkg::DVS_W:0] w_trial;
    logic [vgcd_pkg::DVS_W:0] w_diff;
    logic                     w_ge;
    vgcd_pkg::t_div_word      n_word;
    vgcd_pkg::t_div_word      r_word;
    logic                     r_vld;

    // shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        w_trial = {i_word.rem, i_word.dq[vgcd_pkg::DIV_W-1]};
        w_diff  = w_trial - {1'b0, i_word.dvs};
        w_ge    = (w_trial >= {1'b0, i_word.dvs});
        n_word     = i_word;
        n_word.rem = w_ge ? w_diff[vgcd_pkg::DVS_W-1:0] : w_trial[vgcd_pkg::DVS_W-1:0];
        n_word.dq  = {i_word.dq[vgcd_pkg::DIV_W-2:0], w_ge};
    end

    // hand the word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_word <= n_word;
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

// ===== rtl/vgcd_div_chain.sv =====
// pipelined unsigned divider built as a row of step cells
module vgcd_div_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [vgcd_pkg::DIV_W-1:0]    i_dvd,
    input  logic [vgcd_pkg::DVS_W-1:0]    i_dvs,
    input  vgcd_pkg::t_div_tag            i_tag,
    output logic                          o_vld,
    output logic [vgcd_pkg::DIV_W-1:0]    o_quo,
    output logic [vgcd_pkg::DVS_W-1:0]    o_rem,
    output vgcd_pkg::t_div_tag            o_tag
);

    vgcd_pkg::t_div_word        w_word [vgcd_pkg::DIV_W+1];
    logic [vgcd_pkg::DIV_W:0]   w_vld;

    // chain head: empty remainder, dividend in the shift field
    assign w_word[0] = {{vgcd_pkg::DVS_W{1'b0}}, i_dvd, i_dvs, i_tag};
    assign w_vld[0]  = i_vld;

    // one cell per quotient bit
    for (genvar g = 0; g < vgcd_pkg::DIV_W; g++) begin : g_cell
        vgcd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_word  (w_word[g]),
            .o_vld   (w_vld[g+1]),
            .o_word  (w_word[g+1])
        );
    end

    assign o_vld = w_vld[vgcd_pkg::DIV_W];
    assign o_quo = w_word[vgcd_pkg::DIV_W].dq;
    assign o_rem = w_word[vgcd_pkg::DIV_W].rem;
    assign o_tag = w_word[vgcd_pkg::DIV_W].tag;

endmodule

// ===== rtl/vgcd_table.sv =====
// voxel hash table memory, one write and one registered read port
module vgcd_table (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [vgcd_pkg::ADDR_W-1:0]   i_waddr,
    input  vgcd_pkg::t_entry              i_wdata,
    input  logic [vgcd_pkg::ADDR_W-1:0]   i_raddr,
    output vgcd_pkg::t_entry              o_rdata
);

    vgcd_pkg::t_entry r_mem [vgcd_pkg::TABLE_DEPTH];
    vgcd_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/vgcd_monitor.sv =====
// watches the voxel downsampler channels, predicts every result word and compares
module vgcd_monitor
    import vgcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [95:0]        i_s_tdata,   // px, py, pz
    input  logic [0:0]         i_s_tuser,   // op
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [95:0]        i_m_tdata,   // cx, cy, cz
    input  logic [2:0]         i_m_tuser,   // status
    input  logic               i_m_tlast,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status            status;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               last;
    } t_centroid_word;

    // own copy of the voxel table
    bit              slot_taken [TABLE_DEPTH];
    longint          slot_key   [TABLE_DEPTH][3];
    longint          slot_sum   [TABLE_DEPTH][3];
    longint          slot_count [TABLE_DEPTH];
    int              cursor;
    logic [EDGE_W-1:0] edge_len;

    t_centroid_word  expected_words[$];

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q--;
        return q;
    endfunction

    // one command through the table
    function automatic t_centroid_word voxel_step(logic op, logic [95:0] pts);
        t_centroid_word w;
        longint p[3];
        longint k[3];
        longint h;
        longint n;
        logic [KEY_BITS-1:0] kw;
        int home;
        int idx;
        int hit;
        w = '{ST_EMPTY, 0, 0, 0, 1'b0};
        if (edge_len < EDGE_MIN) begin
            w.status = ST_DISABLED;
        end else if (op == 1'b0) begin
            for (int j = 0; j < 3; j++) begin
                p[j] = longint'($signed(pts[32*j +: 32]));
                kw = KEY_BITS'(floor_quot(p[j], longint'(edge_len)));
                k[j] = longint'($signed(kw));
            end
            h = (k[2] * 116101) % 64'sd10000000000;
            h = ((h + k[1]) * 116101) % 64'sd10000000000;
            h = (h + k[0]) % TABLE_DEPTH;
            if (h < 0)
                h += TABLE_DEPTH;
            home = int'(h);
            hit = 0;
            idx = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                idx = (home + i) % TABLE_DEPTH;
                if (!slot_taken[idx]) begin
                    hit = 1;
                    break;
                end
                if (slot_key[idx][0] == k[0] && slot_key[idx][1] == k[1] &&
                    slot_key[idx][2] == k[2]) begin
                    hit = 2;
                    break;
                end
            end
            if (hit == 0) begin
                w.status = ST_FULL;
            end else if (hit == 1) begin
                slot_taken[idx] = 1'b1;
                for (int j = 0; j < 3; j++) begin
                    slot_key[idx][j] = k[j];
                    slot_sum[idx][j] = p[j];
                end
                slot_count[idx] = 1;
                w.status = ST_NEW;
            end else if (slot_count[idx] >= (1 << COUNT_BITS) - 1) begin
                w.status = ST_SATURATED;
            end else begin
                for (int j = 0; j < 3; j++)
                    slot_sum[idx][j] += p[j];
                slot_count[idx]++;
                w.status = ST_MERGED;
            end
        end else begin
            hit = 0;
            idx = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                idx = (cursor + i) % TABLE_DEPTH;
                if (slot_taken[idx]) begin
                    hit = 1;
                    break;
                end
            end
            if (hit == 0) begin
                w.status = ST_EMPTY;
                w.last = 1'b1;
                cursor = 0;
            end else begin
                n = slot_count[idx];
                w.cx = 32'(floor_quot(slot_sum[idx][0] + n / 2, n));
                w.cy = 32'(floor_quot(slot_sum[idx][1] + n / 2, n));
                w.cz = 32'(floor_quot(slot_sum[idx][2] + n / 2, n));
                slot_taken[idx] = 1'b0;
                cursor = (idx + 1) % TABLE_DEPTH;
                w.last = 1'b1;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_taken[i]) begin
                        w.last = 1'b0;
                        break;
                    end
                end
                w.status = ST_EMITTED;
            end
        end
        return w;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_centroid_word w;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_taken[i] = 1'b0;
            cursor = 0;
            edge_len = EDGE_RESET;
            expected_words.delete();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[PADDR_W-1:2] == REG_VOXEL_EDGE)
                edge_len = i_pwdata[EDGE_W-1:0];
            // command word accepted
            if (i_s_tvalid && i_s_tready)
                expected_words.insert(expected_words.size(),
                                      voxel_step(i_s_tuser[0], i_s_tdata));
            // result word accepted
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word", {29'd0, i_m_tuser}, 32'd0);
                end else begin
                    w = expected_words.pop_front();
                    if (i_m_tuser != w.status)
                        report("status", {29'd0, i_m_tuser}, {29'd0, w.status});
                    if (i_m_tdata[31:0] != w.cx)
                        report("cx", i_m_tdata[31:0], w.cx);
                    if (i_m_tdata[63:32] != w.cy)
                        report("cy", i_m_tdata[63:32], w.cy);
                    if (i_m_tdata[95:64] != w.cz)
                        report("cz", i_m_tdata[95:64], w.cz);
                    if (i_m_tlast != w.last)
                        report("last", {31'd0, i_m_tlast}, {31'd0, w.last});
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

// ===== test/voxel_grid_centroid_downsampler_test.sv =====
// stimulus and verdict for the voxel grid centroid downsampler
module voxel_grid_centroid_downsampler_test;
    import vgcd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 8000000;
    localparam int     STALL_LEN   = 2000;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [95:0]        s_axis_tdata;   // px, py, pz
    logic [0:0]         s_axis_tuser;   // op
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [95:0]        m_axis_tdata;   // cx, cy, cz
    logic [2:0]         m_axis_tuser;   // status
    logic               m_axis_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int     errors;
    int     pending;
    int     tx_idle;
    int     rx_idle;
    int     stall_token;
    int     stall_seen;
    int     stall_left;
    longint cycles;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    voxel_grid_centroid_downsampler uut (.*);

    vgcd_monitor monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("voxel_grid_centroid_downsampler_test: errors");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (stall_token != stall_seen) begin
            stall_seen <= stall_token;
            stall_left <= STALL_LEN;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // offer one command word, return after it is taken
    task automatic send_word(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic ready_seen;
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {z, y, x};
        do begin
            @(negedge i_clk);
            ready_seen = s_axis_tready;
            @(posedge i_clk);
        end while (!ready_seen);
    endtask

    // let every expected word come back, then let the design settle
    task automatic drain_out();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_edge(logic [30:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_VOXEL_EDGE, 2'b00};
        pwdata  <= {1'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // clustered coordinate so that points merge, sometimes the full range
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(99) < 20)
            return $urandom();
        return 32'((int'($urandom_range(0, 5)) - 2) * 40000 +
                   int'($urandom_range(0, 30000)) - 15000);
    endfunction

    task automatic random_words(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 25)
                send_word(OP_DRAIN, $urandom(), $urandom(), $urandom());
            else
                send_word(OP_ADD, rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial begin
        tx_idle       = 0;
        rx_idle       = 0;
        stall_token   = 0;
        stall_seen    = 0;
        stall_left    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // three voxels per home slot so that probe chains overlap and wrap
        for (int k = 0; k < 32; k++)
            for (int j = 0; j < 3; j++)
                send_word(OP_ADD, 32'(k + j * TABLE_DEPTH) << 16, 32'd0, 32'd0);
        send_word(OP_ADD, 32'(TABLE_DEPTH - 1) << 16, 32'd0, 32'd0);
        send_word(OP_ADD, 32'(2 * TABLE_DEPTH - 1) << 16, 32'd0, 32'd0);
        send_word(OP_ADD, (32'd5 << 16) + 32'd1, 32'd7, 32'd9);
        for (int k = 0; k <= 98; k++)
            send_word(OP_DRAIN, '0, '0, '0);
        drain_out();

        // disabled edges
        write_edge(31'd0);
        send_word(OP_ADD, 32'd1, 32'd2, 32'd3);
        send_word(OP_DRAIN, '0, '0, '0);
        drain_out();
        write_edge(31'd654);
        send_word(OP_ADD, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000);
        drain_out();

        // smallest working edge at the coordinate extremes
        write_edge(31'd655);
        send_word(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        drain_out();

        // largest edge: only four voxels per axis
        write_edge(31'h7FFF_FFFF);
        send_word(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
        send_word(OP_ADD, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
        for (int k = 0; k < 6; k++)
            send_word(OP_DRAIN, '0, '0, '0);
        drain_out();

        // rounding ties on both signs, then merge and drain to empty
        write_edge(31'd65536);
        send_word(OP_ADD, 32'd1, 32'hFFFF_FFFF, 32'd0);
        send_word(OP_ADD, 32'd2, 32'hFFFF_FFFE, 32'd0);
        send_word(OP_ADD, 32'hFFFF_0000, 32'd3, 32'd5);
        send_word(OP_ADD, 32'hFFFF_8000, 32'd4, 32'd5);
        for (int k = 0; k < 4; k++)
            send_word(OP_DRAIN, '0, '0, '0);
        drain_out();

        // sender idles less than it works, receiver mostly stalls
        tx_idle = 28;
        rx_idle = 66;
        random_words(30);
        stall_token <= stall_token + 1;
        random_words(30);
        drain_out();

        write_edge(31'd300000);
        tx_idle = 66;
        rx_idle = 28;
        random_words(60);
        drain_out();

        write_edge(31'd20000);
        tx_idle = 0;
        rx_idle = 0;
        random_words(60);
        drain_out();
        repeat (200) @(posedge i_clk);

        if (errors == 0)
            $display("voxel_grid_centroid_downsampler_test: clean");
        else
            $display("voxel_grid_centroid_downsampler_test: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vgcd_pkg.sv
rtl/vgcd_div_cell.sv
rtl/vgcd_div_chain.sv
rtl/vgcd_table.sv
rtl/voxel_grid_centroid_downsampler.sv
test/vgcd_monitor.sv
test/voxel_grid_centroid_downsampler_test.sv
